/* src/postfix_expression_evaluator_defines.svh */
// Assertion macros shared by the postfix evaluator RTL.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pfe assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pfe assertion failed");

`else

`define PFE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PFE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/pfe_pkg.sv */
// Package with types, constants and helpers of the postfix evaluator.
`timescale 1ns / 1ps

package pfe_pkg;

    localparam int DATA_W          = 8;
    localparam int VALUE_W         = 9;
    localparam int STACK_DEPTH_DEF = 128;

    localparam logic [DATA_W-1:0] CODE_ZERO = 8'd48;
    localparam logic [DATA_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [DATA_W-1:0] CH_NINE   = 8'h39;
    localparam logic [DATA_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [DATA_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [DATA_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [DATA_W-1:0] CH_SLASH  = 8'h2F;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        KIND_DIGIT,
        KIND_ADD,
        KIND_SUB,
        KIND_MUL,
        KIND_DIV,
        KIND_BAD
    } t_kind;

    // What a stack cell does on a clock edge.
    typedef enum logic [1:0] {
        SH_HOLD,
        SH_PUSH,
        SH_POP
    } t_shift;

    // A stored code is a signed byte; its value is that byte minus the code of '0'.
    function automatic logic signed [VALUE_W-1:0] decode(input logic [DATA_W-1:0] code);
        logic signed [VALUE_W-1:0] ext;
        ext = $signed({code[DATA_W-1], code});
        return ext - $signed({1'b0, CODE_ZERO});
    endfunction

endpackage

/* src/pfe_if.sv */
// Handshake channels of the postfix evaluator: token input and result output.
`timescale 1ns / 1ps

interface pfe_tok_if;
    logic                        valid;
    logic                        ready;
    logic [pfe_pkg::DATA_W-1:0]  token;
    logic                        last_token;

    modport source (output valid, output token, output last_token, input ready);
    modport sink   (input valid, input token, input last_token, output ready);
endinterface

interface pfe_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [pfe_pkg::VALUE_W-1:0] value;
    logic                              error;

    modport source (output valid, output value, output error, input ready);
    modport sink   (input valid, input value, input error, output ready);
endinterface

/* src/pfe_cell.sv */
// One byte of the shift stack: holds, takes its upper neighbor or its lower neighbor.
`timescale 1ns / 1ps

module pfe_cell (
    input  logic                       i_clk,
    input  pfe_pkg::t_shift            i_mode,
    input  logic [pfe_pkg::DATA_W-1:0] i_above,
    input  logic [pfe_pkg::DATA_W-1:0] i_below,
    output logic [pfe_pkg::DATA_W-1:0] o_code
);

    logic [pfe_pkg::DATA_W-1:0] r_code;
    logic [pfe_pkg::DATA_W-1:0] n_code;

    always_comb begin
        case (i_mode)
            pfe_pkg::SH_PUSH: n_code = i_above;
            pfe_pkg::SH_POP:  n_code = i_below;
            default:          n_code = r_code;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    assign o_code = r_code;

endmodule

/* src/pfe_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pfe_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pfe_pkg::DATA_W-1:0] i_dividend,
    input  logic [pfe_pkg::DATA_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [pfe_pkg::DATA_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(pfe_pkg::DATA_W);

    logic                       r_busy;
    logic                       r_done;
    logic [STEP_W-1:0]          r_step;
    logic [pfe_pkg::DATA_W-1:0] r_rem;
    logic [pfe_pkg::DATA_W-1:0] r_quo;
    logic [pfe_pkg::DATA_W-1:0] r_dvs;
    logic [pfe_pkg::DATA_W:0]   w_part;
    logic [pfe_pkg::DATA_W:0]   w_trial;

    // The dividend shifts out of the top of r_quo while quotient bits enter below.
    assign w_part  = {r_rem, r_quo[pfe_pkg::DATA_W-1]};
    assign w_trial = w_part - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(pfe_pkg::DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_trial[pfe_pkg::DATA_W]) begin
                r_rem <= w_trial[pfe_pkg::DATA_W-1:0];
                r_quo <= {r_quo[pfe_pkg::DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= w_part[pfe_pkg::DATA_W-1:0];
                r_quo <= {r_quo[pfe_pkg::DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* src/postfix_expression_evaluator.sv */
// Top level of the postfix evaluator: control, operand arithmetic and the cell stack.
//
//   channel   dir   payload                 handshake
//   i_tok     in    token, last_token       valid / ready
//   o_res     out   value, error            valid / ready
//
// A digit, an invalid character or + - * passes the execute state; a nonzero
// division also waits in the divide state for the one-bit-per-cycle divider.
// A last item then waits in the finish state until the output register is free
// and moves the top into it. The stack is a chain of byte cells that shift on
// every push and pop. Synchronous reset clears the control state only; the
// output register parts the channels, so tokens are taken while a result waits.
`timescale 1ns / 1ps

`include "postfix_expression_evaluator_defines.svh"

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pfe_tok_if.sink       i_tok,
    pfe_res_if.source     o_res
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int DW    = pfe_pkg::DATA_W;
    localparam int VW    = pfe_pkg::VALUE_W;

    pfe_pkg::t_state r_state;
    pfe_pkg::t_state n_state;
    pfe_pkg::t_kind  w_kind;
    pfe_pkg::t_shift w_top_mode;
    pfe_pkg::t_shift w_rest_mode;

    logic [DW-1:0]      r_tok;
    logic               r_last;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic [CNT_W-1:0]   w_cnt_comb;
    logic               r_err;
    logic               n_err;
    logic               r_out_valid;
    logic signed [VW-1:0] r_out_value;
    logic               r_out_error;

    logic               w_in_ready;
    logic               w_accept;
    logic               w_out_load;
    logic               w_div_start;
    logic               w_div_done;
    logic               w_div_ok;
    logic [DW-1:0]      w_new_code;
    logic [DW-1:0]      w_cells [STACK_DEPTH];

    logic [DW-1:0]          w_right_code;
    logic [DW-1:0]          w_left_code;
    logic signed [VW-1:0]   w_right;
    logic signed [VW-1:0]   w_left;
    logic signed [VW-1:0]   w_add;
    logic signed [VW-1:0]   w_sub;
    logic signed [2*VW-1:0] w_mul;
    logic [VW-1:0]          w_left_abs;
    logic [VW-1:0]          w_right_abs;
    logic [DW-1:0]          w_quo;
    logic [DW-1:0]          w_quo_signed;
    logic [DW-1:0]          w_op_byte;

    // ------------------------------------------------------------------
    // Cell chain. Cell 0 is the top; its upper neighbor is the new code.
    // ------------------------------------------------------------------
    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            logic [DW-1:0]   w_above;
            logic [DW-1:0]   w_below;
            pfe_pkg::t_shift w_mode;

            if (g == 0) begin : g_top
                assign w_above = w_new_code;
                assign w_mode  = w_top_mode;
            end else begin : g_inner
                assign w_above = w_cells[g-1];
                assign w_mode  = w_rest_mode;
            end

            if (g == STACK_DEPTH - 1) begin : g_bottom
                assign w_below = '0;
            end else begin : g_mid
                assign w_below = w_cells[g+1];
            end

            pfe_cell u_cell (
                .i_clk   (i_clk),
                .i_mode  (w_mode),
                .i_above (w_above),
                .i_below (w_below),
                .o_code  (w_cells[g])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Operands and arithmetic. An empty slot reads as code zero.
    // ------------------------------------------------------------------
    assign w_right_code = (r_cnt != '0) ? w_cells[0] : '0;
    assign w_left_code  = (r_cnt > CNT_W'(1)) ? w_cells[1] : '0;
    assign w_right      = pfe_pkg::decode(w_right_code);
    assign w_left       = pfe_pkg::decode(w_left_code);
    assign w_div_ok     = (w_right != '0);

    assign w_add = w_left + w_right;
    assign w_sub = w_left - w_right;
    assign w_mul = w_left * w_right;

    assign w_left_abs  = w_left[VW-1]  ? VW'(-w_left)  : w_left;
    assign w_right_abs = w_right[VW-1] ? VW'(-w_right) : w_right;

    pfe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_left_abs[DW-1:0]),
        .i_divisor  (w_right_abs[DW-1:0]),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // The stack holds still during a division, so the operand signs are still valid.
    assign w_quo_signed = (w_left[VW-1] ^ w_right[VW-1]) ? DW'(-w_quo) : w_quo;

    always_comb begin
        case (w_kind)
            pfe_pkg::KIND_ADD: w_op_byte = w_add[DW-1:0];
            pfe_pkg::KIND_SUB: w_op_byte = w_sub[DW-1:0];
            pfe_pkg::KIND_MUL: w_op_byte = w_mul[DW-1:0];
            default:           w_op_byte = w_quo_signed;
        endcase
    end

    // Two pops of which the empty ones are lost, then one push.
    assign w_cnt_comb = (r_cnt > CNT_W'(1)) ? (r_cnt - CNT_W'(1)) : CNT_W'(1);

    always_comb begin
        case (r_tok) inside
            [pfe_pkg::CH_ZERO:pfe_pkg::CH_NINE]: w_kind = pfe_pkg::KIND_DIGIT;
            pfe_pkg::CH_PLUS:                     w_kind = pfe_pkg::KIND_ADD;
            pfe_pkg::CH_MINUS:                    w_kind = pfe_pkg::KIND_SUB;
            pfe_pkg::CH_STAR:                     w_kind = pfe_pkg::KIND_MUL;
            pfe_pkg::CH_SLASH:                    w_kind = pfe_pkg::KIND_DIV;
            default:                              w_kind = pfe_pkg::KIND_BAD;
        endcase
    end

    // ------------------------------------------------------------------
    // Control: next state.
    // ------------------------------------------------------------------
    assign w_accept   = i_tok.valid && w_in_ready;
    assign w_out_load = (r_state == pfe_pkg::ST_FINISH) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            pfe_pkg::ST_IDLE: begin
                if (w_accept) n_state = pfe_pkg::ST_EXEC;
            end
            pfe_pkg::ST_EXEC: begin
                if (w_kind == pfe_pkg::KIND_DIV && w_div_ok) begin
                    n_state = pfe_pkg::ST_DIV;
                end else begin
                    n_state = r_last ? pfe_pkg::ST_FINISH : pfe_pkg::ST_IDLE;
                end
            end
            pfe_pkg::ST_DIV: begin
                if (w_div_done) n_state = r_last ? pfe_pkg::ST_FINISH : pfe_pkg::ST_IDLE;
            end
            pfe_pkg::ST_FINISH: begin
                if (w_out_load) n_state = pfe_pkg::ST_IDLE;
            end
            default: n_state = pfe_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control: outputs.
    // ------------------------------------------------------------------
    always_comb begin
        w_in_ready  = 1'b0;
        w_top_mode  = pfe_pkg::SH_HOLD;
        w_rest_mode = pfe_pkg::SH_HOLD;
        w_new_code  = r_tok;
        w_div_start = 1'b0;
        n_cnt       = r_cnt;
        n_err       = r_err;
        case (r_state)
            pfe_pkg::ST_IDLE: begin
                w_in_ready = 1'b1;
            end
            pfe_pkg::ST_EXEC: begin
                case (w_kind)
                    pfe_pkg::KIND_DIGIT: begin
                        if (r_cnt != CNT_W'(STACK_DEPTH)) begin
                            w_top_mode  = pfe_pkg::SH_PUSH;
                            w_rest_mode = pfe_pkg::SH_PUSH;
                            n_cnt       = r_cnt + CNT_W'(1);
                        end
                    end
                    pfe_pkg::KIND_ADD, pfe_pkg::KIND_SUB, pfe_pkg::KIND_MUL: begin
                        w_new_code  = w_op_byte + pfe_pkg::CODE_ZERO;
                        w_top_mode  = pfe_pkg::SH_PUSH;
                        w_rest_mode = pfe_pkg::SH_POP;
                        n_cnt       = w_cnt_comb;
                    end
                    pfe_pkg::KIND_DIV: begin
                        if (w_div_ok) begin
                            w_div_start = 1'b1;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    default: begin
                        n_err = 1'b1;
                    end
                endcase
            end
            pfe_pkg::ST_DIV: begin
                if (w_div_done) begin
                    w_new_code  = w_op_byte + pfe_pkg::CODE_ZERO;
                    w_top_mode  = pfe_pkg::SH_PUSH;
                    w_rest_mode = pfe_pkg::SH_POP;
                    n_cnt       = w_cnt_comb;
                end
            end
            pfe_pkg::ST_FINISH: begin
                if (w_out_load) begin
                    n_cnt = '0;
                    n_err = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfe_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tok  <= i_tok.token;
            r_last <= i_tok.last_token;
        end
        if (w_out_load) begin
            r_out_value <= w_right;
            r_out_error <= r_err;
        end
    end

    assign i_tok.ready = w_in_ready;
    assign o_res.valid = r_out_valid;
    assign o_res.value = r_out_value;
    assign o_res.error = r_out_error;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `PFE_ASSERT_NOW(a_cnt_in_range, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(STACK_DEPTH))
    `PFE_ASSERT_NOW(a_div_done_in_div, i_clk, i_rst_n, w_div_done, r_state == pfe_pkg::ST_DIV)
    `PFE_ASSERT_NEXT(a_emit_clears, i_clk, i_rst_n, w_out_load, (r_cnt == '0) && !r_err && r_out_valid)

endmodule

/* dv/pfe_result_checker.sv */
// Result checker for the postfix evaluator: tracks the token stream and compares each result.
`timescale 1ns / 1ps

module pfe_result_checker #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_tok_valid,
    input  logic                               i_tok_ready,
    input  logic [pfe_pkg::DATA_W-1:0]         i_token,
    input  logic                               i_last_token,
    input  logic                               i_res_valid,
    input  logic                               i_res_ready,
    input  logic signed [pfe_pkg::VALUE_W-1:0] i_value,
    input  logic                               i_error,
    output int                                 o_mismatches,
    output int                                 o_pending,
    output int                                 o_checked,
    output int                                 o_peak_depth
);

    typedef struct packed {
        logic signed [pfe_pkg::VALUE_W-1:0] value;
        logic                               error;
    } t_answer;

    logic [pfe_pkg::DATA_W-1:0] stack_codes [STACK_DEPTH];
    int unsigned                stack_fill;
    bit                         error_flag;
    t_answer                    answers_due [$];
    t_answer                    want;

    // A stored byte is read as a signed number offset by the code of '0'.
    function automatic int code_value(input logic [pfe_pkg::DATA_W-1:0] code);
        int v;
        v = $signed(code);
        return v - int'(pfe_pkg::CODE_ZERO);
    endfunction

    function automatic void push_code(input logic [pfe_pkg::DATA_W-1:0] code);
        if (stack_fill < STACK_DEPTH) begin
            stack_codes[stack_fill] = code;
            stack_fill++;
            if (stack_fill > o_peak_depth) o_peak_depth = stack_fill;
        end
    endfunction

    function automatic logic [pfe_pkg::DATA_W-1:0] pop_code();
        if (stack_fill == 0) return '0;
        stack_fill--;
        return stack_codes[stack_fill];
    endfunction

    function automatic int peek_value(input int unsigned below_top);
        if (stack_fill <= below_top) return code_value('0);
        return code_value(stack_codes[stack_fill - 1 - below_top]);
    endfunction

    function automatic void apply_token(input logic [pfe_pkg::DATA_W-1:0] tok);
        int rhs;
        int lhs;
        int outcome;
        if (tok >= pfe_pkg::CH_ZERO && tok <= pfe_pkg::CH_NINE) begin
            push_code(tok);
            return;
        end
        if (!(tok inside {pfe_pkg::CH_PLUS, pfe_pkg::CH_MINUS,
                          pfe_pkg::CH_STAR, pfe_pkg::CH_SLASH})) begin
            error_flag = 1'b1;
            return;
        end
        rhs = peek_value(0);
        lhs = peek_value(1);
        // A zero divisor flags the expression and leaves both operands in place.
        if (tok == pfe_pkg::CH_SLASH && rhs == 0) begin
            error_flag = 1'b1;
            return;
        end
        void'(pop_code());
        void'(pop_code());
        case (tok)
            pfe_pkg::CH_PLUS:  outcome = lhs + rhs;
            pfe_pkg::CH_MINUS: outcome = lhs - rhs;
            pfe_pkg::CH_STAR:  outcome = lhs * rhs;
            default:           outcome = lhs / rhs;
        endcase
        push_code(pfe_pkg::DATA_W'(outcome + int'(pfe_pkg::CODE_ZERO)));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stack_fill = 0;
            error_flag = 1'b0;
            answers_due.delete();
        end else begin
            if (i_tok_valid && i_tok_ready) begin
                apply_token(i_token);
                if (i_last_token) begin
                    want.value = pfe_pkg::VALUE_W'(code_value(pop_code()));
                    want.error = error_flag;
                    answers_due.push_back(want);
                    stack_fill = 0;
                    error_flag = 1'b0;
                end
            end
            if (i_res_valid && i_res_ready) begin
                o_checked++;
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result value %0d error %0b",
                             $time, i_value, i_error);
                    o_mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    if (want.value !== i_value) begin
                        $display("%0t: value mismatch: expected %0d, got %0d",
                                 $time, want.value, i_value);
                        o_mismatches++;
                    end
                    if (want.error !== i_error) begin
                        $display("%0t: error flag mismatch: expected %0b, got %0b",
                                 $time, want.error, i_error);
                        o_mismatches++;
                    end
                end
            end
        end
        o_pending = answers_due.size();
    end

endmodule

/* dv/postfix_expression_evaluator_tb.sv */
// Testbench top for the postfix evaluator: clock, reset, token stimulus, result flow and verdict.
`timescale 1ns / 1ps

module postfix_expression_evaluator_tb;

    localparam int RANDOM_TOKENS = 1200;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 20;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pfe_tok_if tok_ch ();
    pfe_res_if res_ch ();

    int mismatches;
    int results_pending;
    int results_checked;
    int peak_depth;

    int send_idle_pct;
    int take_stall_pct;
    int hold_requests;
    int holds_done;
    int tokens_sent;
    int expressions_sent;
    int quiet_cycles;
    int phase_end;

    logic [pfe_pkg::DATA_W-1:0] expr_tokens [$];

    postfix_expression_evaluator #(
        .STACK_DEPTH(pfe_pkg::STACK_DEPTH_DEF)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok_ch),
        .o_res   (res_ch)
    );

    pfe_result_checker #(
        .STACK_DEPTH(pfe_pkg::STACK_DEPTH_DEF)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tok_valid  (tok_ch.valid),
        .i_tok_ready  (tok_ch.ready),
        .i_token      (tok_ch.token),
        .i_last_token (tok_ch.last_token),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_value      (res_ch.value),
        .i_error      (res_ch.error),
        .o_mismatches (mismatches),
        .o_pending    (results_pending),
        .o_checked    (results_checked),
        .o_peak_depth (peak_depth)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_done) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                holds_done++;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= take_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (tok_ch.valid && tok_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without a handshake", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Valid stays high after an item unless the next one is preceded by an idle gap.
    task automatic send_token(input logic [pfe_pkg::DATA_W-1:0] code, input logic is_last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            tok_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        tok_ch.valid      <= 1'b1;
        tok_ch.token      <= code;
        tok_ch.last_token <= is_last;
        do @(posedge i_clk); while (!tok_ch.ready);
        tokens_sent++;
    endtask

    task automatic send_expression();
        for (int k = 0; k < expr_tokens.size(); k++) begin
            send_token(expr_tokens[k], k == expr_tokens.size() - 1);
        end
        expressions_sent++;
    endtask

    task automatic send_text(input string text);
        expr_tokens.delete();
        for (int k = 0; k < text.len(); k++) expr_tokens.push_back(text[k]);
        send_expression();
    endtask

    function automatic logic [pfe_pkg::DATA_W-1:0] random_digit();
        return pfe_pkg::CH_ZERO + pfe_pkg::DATA_W'($urandom_range(9));
    endfunction

    function automatic logic [pfe_pkg::DATA_W-1:0] random_operator();
        case ($urandom_range(3))
            0:       return pfe_pkg::CH_PLUS;
            1:       return pfe_pkg::CH_MINUS;
            2:       return pfe_pkg::CH_STAR;
            default: return pfe_pkg::CH_SLASH;
        endcase
    endfunction

    // Builds a balanced expression with the given number of operators, then corrupts
    // a few characters so that errors also show up in the middle of real work.
    task automatic build_balanced(input int ops);
        int depth;
        int done_ops;
        expr_tokens.delete();
        expr_tokens.push_back(random_digit());
        depth    = 1;
        done_ops = 0;
        while (done_ops < ops || depth > 1) begin
            if (depth < 2 || (done_ops + depth - 1 < ops && $urandom_range(1) == 0)) begin
                expr_tokens.push_back(random_digit());
                depth++;
            end else begin
                expr_tokens.push_back(random_operator());
                depth--;
                done_ops++;
            end
        end
        for (int k = 0; k < expr_tokens.size(); k++) begin
            if ($urandom_range(19) == 0) expr_tokens[k] = pfe_pkg::DATA_W'($urandom_range(255));
        end
    endtask

    // Pushes around the stack capacity, so some pushes land on a full stack.
    task automatic build_deep();
        int pushes;
        pushes = $urandom_range(pfe_pkg::STACK_DEPTH_DEF + 12, pfe_pkg::STACK_DEPTH_DEF - 8);
        expr_tokens.delete();
        repeat (pushes) expr_tokens.push_back(random_digit());
        repeat ($urandom_range(20)) expr_tokens.push_back(random_operator());
    endtask

    task automatic build_noise();
        expr_tokens.delete();
        repeat ($urandom_range(6, 1)) begin
            case ($urandom_range(3))
                0:       expr_tokens.push_back(random_digit());
                1:       expr_tokens.push_back(random_operator());
                default: expr_tokens.push_back(pfe_pkg::DATA_W'($urandom_range(255)));
            endcase
        end
    endtask

    initial begin
        int pick;
        int directed_tokens;
        tok_ch.valid      = 1'b0;
        tok_ch.token      = '0;
        tok_ch.last_token = 1'b0;
        send_idle_pct     = 0;
        take_stall_pct    = 0;
        hold_requests     = 0;
        holds_done        = 0;
        tokens_sent       = 0;
        expressions_sent  = 0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: range extremes, every operator, truncating division, division by
        // zero, invalid characters at both ends of the byte, and operators on an empty stack.
        send_text("0");
        send_text("99*1-");
        send_text("99*2-");
        send_text("27-2/");
        send_text("50/");
        send_text("+");
        send_text("/");
        expr_tokens = '{pfe_pkg::CH_ZERO + 8'd7, 8'hFF};
        send_expression();
        expr_tokens = '{8'h00};
        send_expression();
        directed_tokens = tokens_sent;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  take_stall_pct = 0;  end
                1: begin send_idle_pct = 55; take_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  take_stall_pct = 55; end
                default: begin send_idle_pct = 7; take_stall_pct = 7; end
            endcase
            // With the sender at full rate, a long hold on results backs up the input.
            if (phase == 0) hold_requests++;
            phase_end = directed_tokens + (phase + 1) * RANDOM_TOKENS / 4;
            while (tokens_sent < phase_end) begin
                pick = $urandom_range(99);
                if (pick < 4) build_deep();
                else if (pick < 20) build_noise();
                else build_balanced($urandom_range(10, 1));
                send_expression();
            end
        end

        @(negedge i_clk);
        tok_ch.valid <= 1'b0;
        wait (results_pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d tokens in %0d expressions; %0d results checked;",
                 tokens_sent, expressions_sent, results_checked);
        $display("Ran free flow, sender gaps, receiver stalls and mixed gaps, with one long hold; deepest stack %0d of %0d.",
                 peak_depth, pfe_pkg::STACK_DEPTH_DEF);
        if (mismatches == 0 && results_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
